// ===== design/text_console_char_writer_unit_defines.svh =====
// Assertion macros for the console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TCW_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define TCW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// Package for the text console writer: sizes, codes, word types and states.
package tcw_pkg;

    localparam int TEXT_COLUMNS = 80;
    localparam int TEXT_ROWS    = 25;
    localparam int CELL_COUNT   = TEXT_COLUMNS * TEXT_ROWS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(TEXT_COLUMNS);
    localparam int LINE_W = $clog2(TEXT_ROWS);

    // field widths of the words on the ports
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;

    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0F20;
    localparam int                TAB_STEP    = 4;   // power of two

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         char_code;
        logic [7:0]         color;
        logic [INDEX_W-1:0] cell_index;
    } tcw_item_t;

    typedef struct packed {
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CELL_W-1:0]    cell_data;
        logic                 scrolled;
    } tcw_result_t;

    // cursor update for one put
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic              scroll;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_offset;
    } tcw_move_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } tcw_state_t;

endpackage

// ===== design/text_console_char_writer_unit.sv =====
// Top level of the text console writer: cell memory, cursor and control.
//
//  channel  | signals                         | handshake
//  ---------+---------------------------------+--------------------------------
//  command  | start, busy, item               | word taken when start && !busy
//  result   | done, result                    | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_data  | blank_cell written on valid && ready
//
//  Put without scroll: done_reg set on accept. Read: via ST_READ (synchronous read of the cell RAM).
//  Put that scrolls: via ST_BLANK, which blanks the freed row at one RAM write a cycle.
//  After reset a clearing pass writes every cell, busy meanwhile.
//  The receiver cannot stall: each result word is shown for one cycle only.
module text_console_char_writer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tcw_pkg::tcw_item_t           item,
    output logic                         done,
    output tcw_pkg::tcw_result_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tcw_pkg::CELL_W-1:0]   cfg_data
);
    import tcw_pkg::*;
    `include "text_console_char_writer_unit_defines.svh"

    // Scrolling never moves cells: the grid is a ring of rows and top_reg holds the
    // physical address of the first cell of logical row 0.

    logic [CELL_W-1:0] cells [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    tcw_state_t        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_left_reg, sweep_left_next;
    logic              done_reg, done_next;
    tcw_result_t       res_reg, res_next;
    logic              in_range_reg, in_range_next;
    logic [CELL_W-1:0] blank_cell_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] put_addr;
    logic              accept;
    logic              idx_ok;
    tcw_move_t         move;

    // logical offset plus ring base, folded back into the grid
    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] offs,
                                                   input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, offs} + {1'b0, base};
        if (sum >= (ADDR_W+1)'(CELL_COUNT))
        begin
            sum = sum - (ADDR_W+1)'(CELL_COUNT);
        end
        return sum[ADDR_W-1:0];
    endfunction

    tcw_cursor_step u_cursor_step (
        .col_cur   (col_reg),
        .line_cur  (line_reg),
        .char_code (item.char_code),
        .move      (move)
    );

    assign accept    = start && !busy;
    assign idx_ok    = 32'(item.cell_index) < 32'(CELL_COUNT);
    assign mem_raddr = ring_addr(ADDR_W'(item.cell_index), top_reg);
    assign put_addr  = ring_addr(move.wr_offset, top_reg);

    // cell RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cells[mem_raddr];
    end

    // config register, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_cell_reg <= BLANK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            blank_cell_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            col_reg        <= '0;
            line_reg       <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= ADDR_W'(CELL_COUNT - 1);
            done_reg       <= 1'b0;
            in_range_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_left_reg <= sweep_left_next;
            done_reg       <= done_next;
            in_range_reg   <= in_range_next;
        end
    end

    // result word, payload only
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        in_range_next   = in_range_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = blank_cell_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // power-up fill with the reset blank, not the config register
                mem_we          = 1'b1;
                mem_wdata       = BLANK_RESET;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                sweep_left_next = sweep_left_reg - 1'b1;
                if (sweep_left_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_READ)
                    begin
                        // RAM read issued at this edge from mem_raddr
                        in_range_next = idx_ok;
                        state_next    = ST_READ;
                    end
                    else
                    begin
                        col_next  = move.col;
                        line_next = move.line;
                        mem_we    = move.wr_en;
                        mem_waddr = put_addr;
                        mem_wdata = {item.color, item.char_code};
                        res_next.cursor_col = CUR_COL_W'(move.col);
                        res_next.cursor_row = CUR_ROW_W'(move.line);
                        res_next.cell_data  = '0;
                        res_next.scrolled   = move.scroll;
                        if (move.scroll)
                        begin
                            // old top row becomes the new bottom row; blank it
                            top_next        = ring_addr(ADDR_W'(TEXT_COLUMNS), top_reg);
                            sweep_addr_next = top_reg;
                            sweep_left_next = ADDR_W'(TEXT_COLUMNS - 1);
                            state_next      = ST_BLANK;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_next.cursor_col = CUR_COL_W'(col_reg);
                res_next.cursor_row = CUR_ROW_W'(line_reg);
                res_next.cell_data  = in_range_reg ? rdata_reg : '0;
                res_next.scrolled   = 1'b0;
                done_next           = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_BLANK:
            begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                sweep_left_next = sweep_left_reg - 1'b1;
                if (sweep_left_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    `TCW_ASSERT_NEXT(a_read_goes_read, clk, rst_n, accept && item.func == FUNC_READ,
        state_reg == ST_READ, "read word did not enter the read state")
    `TCW_ASSERT_SAME(a_scroll_last_row, clk, rst_n, done && result.scrolled,
        result.cursor_row == CUR_ROW_W'(TEXT_ROWS - 1), "scroll left cursor off last row")
    `TCW_ASSERT_SAME(a_top_in_grid, clk, rst_n, 1'b1,
        32'(top_reg) < 32'(CELL_COUNT), "ring base outside grid")
    `TCW_ASSERT_NEXT(a_blank_ends, clk, rst_n, state_reg == ST_BLANK && sweep_left_reg == '0,
        done && result.scrolled && state_reg == ST_IDLE, "row blanking ended without result")

endmodule

// ===== design/tcw_cursor_step.sv =====
// Cursor arithmetic for one put: new column and line, scroll and cell offset.
module tcw_cursor_step (
    input  logic [tcw_pkg::COL_W-1:0]  col_cur,
    input  logic [tcw_pkg::LINE_W-1:0] line_cur,
    input  logic [7:0]                 char_code,
    output tcw_pkg::tcw_move_t         move
);
    import tcw_pkg::*;

    logic [COL_W:0]  col_w;
    logic [COL_W:0]  tab_sum;
    logic [LINE_W:0] line_w;
    logic            wr_en;

    assign tab_sum = {1'b0, col_cur} + (COL_W+1)'(TAB_STEP);

    always_comb
    begin
        col_w  = {1'b0, col_cur};
        line_w = {1'b0, line_cur};
        wr_en  = 1'b0;
        case (char_code)
            CH_TAB:
            begin
                col_w = tab_sum & ~((COL_W+1)'(TAB_STEP - 1));
            end
            CH_CR:
            begin
                col_w = '0;
            end
            CH_LF:
            begin
                col_w  = '0;
                line_w = line_w + 1'b1;
            end
            CH_BS:
            begin
                if (col_cur != '0)
                begin
                    col_w = col_w - 1'b1;
                end
            end
            default:
            begin
                if (char_code inside {[CH_SPACE:8'hFF]})
                begin
                    wr_en = 1'b1;
                    col_w = col_w + 1'b1;
                end
            end
        endcase

        if (col_w >= (COL_W+1)'(TEXT_COLUMNS))
        begin
            col_w  = '0;
            line_w = line_w + 1'b1;
        end

        move.scroll = 1'b0;
        if (line_w >= (LINE_W+1)'(TEXT_ROWS))
        begin
            line_w      = (LINE_W+1)'(TEXT_ROWS - 1);
            move.scroll = 1'b1;
        end

        move.col       = col_w[COL_W-1:0];
        move.line      = line_w[LINE_W-1:0];
        move.wr_en     = wr_en;
        // logical offset of the cell under the old cursor
        move.wr_offset = ADDR_W'(line_cur) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(col_cur);
    end

endmodule

// ===== tb/tb_text_console_char_writer_unit.sv =====
// Self-checking testbench for the text console writer: shadow screen, stimulus and checks.
module tb_text_console_char_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // ------------------------------------------------------------------
    // Shadow of the console: its own copy of the grid, the cursor and the
    // blank word. Each accepted command word is played into it at once and
    // the result word it should give is queued; result words from the block
    // are checked in order against that queue.
    // ------------------------------------------------------------------
    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        logic [CELL_W-1:0] blank_word;
        int unsigned       cur_col;
        int unsigned       cur_row;
        tcw_result_t       expected_results [$];
        int                mismatch_count;
        int                words_checked;

        function new();
            blank_word     = BLANK_RESET;
            cur_col        = 0;
            cur_row        = 0;
            mismatch_count = 0;
            words_checked  = 0;
            foreach (cells[i])
                cells[i] = BLANK_RESET;
        endfunction

        function void set_blank(logic [CELL_W-1:0] value);
            blank_word = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // grid moves up one line, freed bottom line takes the blank word
        function void scroll_grid();
            for (int i = 0; i < CELL_COUNT - TEXT_COLUMNS; i++)
                cells[i] = cells[i + TEXT_COLUMNS];
            for (int i = CELL_COUNT - TEXT_COLUMNS; i < CELL_COUNT; i++)
                cells[i] = blank_word;
        endfunction

        function tcw_result_t predict_console_step(tcw_item_t w);
            tcw_result_t r;
            int unsigned pos;
            r = '0;
            if (w.func == FUNC_READ) begin
                if (w.cell_index < CELL_COUNT)
                    r.cell_data = cells[w.cell_index];
            end
            else begin
                if (w.char_code == CH_TAB)
                    cur_col = ((cur_col + TAB_STEP) / TAB_STEP) * TAB_STEP;
                else if (w.char_code == CH_CR)
                    cur_col = 0;
                else if (w.char_code == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (w.char_code == CH_BS) begin
                    if (cur_col != 0)
                        cur_col--;
                end
                else if (w.char_code >= CH_SPACE) begin
                    pos = cur_row * TEXT_COLUMNS + cur_col;
                    if (pos < CELL_COUNT)
                        cells[pos] = {w.color, w.char_code};
                    cur_col++;
                end
                // wrap, then scroll with the cursor held on the bottom line
                if (cur_col >= TEXT_COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= TEXT_ROWS) begin
                    scroll_grid();
                    cur_row    = TEXT_ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            r.cursor_col = CUR_COL_W'(cur_col);
            r.cursor_row = CUR_ROW_W'(cur_row);
            return r;
        endfunction

        function void note_word(tcw_item_t w);
            expected_results.push_back(predict_console_step(w));
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(tcw_result_t got);
            tcw_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result word %h with no command pending", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.cursor_col !== want.cursor_col)
                report_mismatch($sformatf("word %0d cursor_col got %0d want %0d",
                                          words_checked, got.cursor_col, want.cursor_col));
            if (got.cursor_row !== want.cursor_row)
                report_mismatch($sformatf("word %0d cursor_row got %0d want %0d",
                                          words_checked, got.cursor_row, want.cursor_row));
            if (got.cell_data !== want.cell_data)
                report_mismatch($sformatf("word %0d cell_data got %h want %h",
                                          words_checked, got.cell_data, want.cell_data));
            if (got.scrolled !== want.scrolled)
                report_mismatch($sformatf("word %0d scrolled got %b want %b",
                                          words_checked, got.scrolled, want.scrolled));
            words_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block and its ports
    // ------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    tcw_item_t         item;
    logic              done;
    tcw_result_t       result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CELL_W-1:0] cfg_data;

    console_scoreboard board = new();
    int                burst_left = 0;

    text_console_char_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch both sides at the edge. Inputs change only by NBA at the edge,
    // so the values read here are the ones the block sampled. A word taken
    // is noted before any result at the same edge is checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                board.note_word(item);
            if (done)
                board.check_result(result);
        end
    end

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic tcw_item_t make_word(logic f, logic [7:0] code, logic [7:0] attr,
                                            int unsigned idx);
        tcw_item_t w;
        w.func       = f;
        w.char_code  = code;
        w.color      = attr;
        w.cell_index = INDEX_W'(idx);
        return w;
    endfunction

    function automatic tcw_item_t put_word(logic [7:0] code, logic [7:0] attr);
        // index is unused on a put; random so its bits still toggle
        return make_word(FUNC_PUT, code, attr, $urandom_range(0, 2047));
    endfunction

    function automatic tcw_item_t read_word(int unsigned idx);
        return make_word(FUNC_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         idx);
    endfunction

    function automatic tcw_item_t noise_word();
        return make_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), $urandom_range(0, 2047));
    endfunction

    // control codes other than tab, CR, LF and backspace leave the block untouched
    function automatic bit is_ignored(tcw_item_t w);
        return w.func == FUNC_PUT && w.char_code < CH_SPACE && w.char_code != CH_TAB &&
               w.char_code != CH_CR && w.char_code != CH_LF && w.char_code != CH_BS;
    endfunction

    // ------------------------------------------------------------------
    // Command side: bursts of back-to-back words with random gaps between.
    // start stays high across a burst; each word waits for !busy.
    // ------------------------------------------------------------------
    task automatic send_word(input tcw_item_t w);
        int gap;
        int pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                gap = 0;
            else if (pick < 90)
                gap = $urandom_range(1, 6);
            else
                gap = $urandom_range(15, 60);
            if (gap > 0) begin
                start <= 1'b0;
                item  <= noise_word();   // junk on the bus while idle
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
    endtask

    // hold off until every result word has come back
    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_blank(input logic [CELL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_blank(value);
    endtask

    task automatic run_directed();
        // reads first: cells still hold the reset blank; edge indexes and out of range
        send_word(read_word(0));
        send_word(read_word(CELL_COUNT - 1));
        send_word(read_word(CELL_COUNT));
        send_word(read_word(2047));
        // printable extremes and colour extremes
        send_word(put_word(CH_SPACE, 8'h00));
        send_word(put_word(8'hFF, 8'hFF));
        send_word(put_word(8'h7F, 8'h5A));
        // control codes that do nothing
        send_word(put_word(8'h00, 8'hC3));
        send_word(put_word(8'h1F, 8'h3C));
        // backspace mid line, tabs, CR, backspace at column zero, LF
        send_word(put_word(CH_BS, 8'h11));
        send_word(put_word(CH_TAB, 8'h22));
        send_word(put_word(CH_TAB, 8'h33));
        send_word(put_word(CH_CR, 8'h44));
        send_word(put_word(CH_BS, 8'h55));
        send_word(put_word(CH_LF, 8'h66));
        send_word(put_word("q", 8'h81));
        // read back what was written and a line still blank
        send_word(read_word(0));
        send_word(read_word(1));
        send_word(read_word(2));
        send_word(read_word(TEXT_COLUMNS));
        send_word(read_word(TEXT_COLUMNS + 1));
        send_word(read_word(5 * TEXT_COLUMNS));
    endtask

    // Mostly well-formed console traffic: text runs, newlines, tabs, backspaces
    // and read-back near the cursor, with a share of raw noise words.
    task automatic run_random(input int target);
        int          counted;
        int          kind;
        int          len;
        int          row;
        logic [7:0]  attr;
        tcw_item_t   w;
        counted = 0;
        while (counted < target) begin
            kind = $urandom_range(0, 99);
            attr = 8'($urandom_range(0, 255));
            if (kind < 40) begin
                // text run, now and then long enough to wrap
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        attr = 8'($urandom_range(0, 255));
                    w = put_word(8'($urandom_range(CH_SPACE, 255)), attr);
                    send_word(w);
                    counted++;
                end
            end
            else if (kind < 55) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_word(put_word(CH_CR, attr));
                    counted++;
                end
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    send_word(put_word(CH_LF, attr));
                    counted++;
                end
            end
            else if (kind < 65) begin
                // tab runs; long ones overflow the line
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 22)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_word(put_word(CH_TAB, attr));
                    counted++;
                end
            end
            else if (kind < 72) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_word(put_word(CH_CR, attr));
                    counted++;
                end
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send_word(put_word(CH_BS, attr));
                    counted++;
                end
            end
            else if (kind < 87) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            // cursor line or the one above it
                            row = board.cur_row;
                            if (row > 0 && $urandom_range(0, 1))
                                row--;
                            w = read_word(row * TEXT_COLUMNS + $urandom_range(0, 79));
                        end
                        1:       w = read_word($urandom_range(CELL_COUNT, 2047));
                        default: w = read_word($urandom_range(0, CELL_COUNT - 1));
                    endcase
                    send_word(w);
                    counted++;
                end
            end
            else begin
                w = noise_word();
                send_word(w);
                if (!is_ignored(w))
                    counted++;
            end
            // occasional full hold-off mid phase
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CELL_W-1:0] blank_settings [4];
        int                guard;
        blank_settings[0] = '0;
        blank_settings[1] = '1;
        blank_settings[2] = CELL_W'($urandom_range(0, 65535));
        blank_settings[3] = BLANK_RESET;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass holds busy; the first word simply waits it out
        run_directed();
        wait_drained();

        foreach (blank_settings[p]) begin
            write_blank(blank_settings[p]);
            run_random(125);
            wait_drained();
        end

        // drain with a bound, then wait for strays
        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (board.pending() != 0 && guard < 4000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d result words never came", board.pending()));

        if (board.mismatch_count == 0)
            $display("PASS text_console_char_writer_unit");
        else
            $display("FAIL text_console_char_writer_unit");
        $finish;
    end

    // generous bound: ~600 words, each with a scroll and the longest gap, stay under 1 ms
    initial begin
        #5_000_000;
        $display("FAIL text_console_char_writer_unit");
        $finish;
    end

endmodule
